/* src/ptcm_pkg.sv */
// ----------------------------------------------------------------------------
// ptcm_pkg
// Shared types and constants for the prepaid time-credit meter: the item and
// result beats, operation and register codes, sequencer states and the
// request/response bundles of the shared divider.
// ----------------------------------------------------------------------------
package ptcm_pkg;

  localparam int CREDIT_W   = 14;
  localparam int WORD_W     = 16;
  localparam int DISP_W     = 11;
  localparam int CNT_W      = 4;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int DIVIDEND_W = PROD_W + 4;
  localparam int DIVISOR_W  = WORD_W + 4;
  localparam int CFG_IDX_W  = 2;

  // x / 10 as (x * DIV10_RECIP) >> DIV10_SHIFT, exact for any 14-bit x
  localparam int DIV10_RECIP = 6554;
  localparam int DIV10_SHIFT = 16;
  localparam int DIV10_PROD_W = CREDIT_W + 13;

  localparam logic [2:0] OP_RESTORE = 3'd0;
  localparam logic [2:0] OP_ADD     = 3'd1;
  localparam logic [2:0] OP_REFUND  = 3'd2;
  localparam logic [2:0] OP_DISPLAY = 3'd3;
  localparam logic [2:0] OP_MINUTE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_PER_UNIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MONEY_PER_UNIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTORY_MODE   = 2'd2;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [WORD_W-1:0] load_value;
    logic              load_ok;
    logic [WORD_W-1:0] money_amount;
  } item_t;

  typedef struct packed {
    logic [CREDIT_W-1:0] time_left;
    logic [DISP_W-1:0]   display_minutes;
    logic                flash_bit;
    logic                relay_on;
    logic                display_valid;
    logic                save_request;
    logic [WORD_W-1:0]   refund_amount;
    logic                clear_event;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_SCALE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* src/ptcm_div.sv */
// ----------------------------------------------------------------------------
// ptcm_div
// Restoring unsigned divider, one quotient bit per cycle. Pulses done with the
// last step's result; the quotient holds until the next start.
// ----------------------------------------------------------------------------
module ptcm_div (
  input  logic               clk,
  input  logic               rst,
  input  ptcm_pkg::div_req_t req,
  output ptcm_pkg::div_rsp_t rsp
);
  import ptcm_pkg::*;

  localparam int STEP_W = $clog2(DIVIDEND_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

  logic                  busy;
  logic                  done;
  logic [STEP_W-1:0]     step;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  divisor;

  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    diff;
  logic [DIVISOR_W-1:0]  rem_next;
  logic [DIVIDEND_W-1:0] quo_next;

  always_comb begin
    rem_sh = {rem, quo[DIVIDEND_W-1]};
    diff   = rem_sh - {1'b0, divisor};
    if (!diff[DIVISOR_W]) begin
      rem_next = diff[DIVISOR_W-1:0];
      quo_next = {quo[DIVIDEND_W-2:0], 1'b1};
    end else begin
      rem_next = rem_sh[DIVISOR_W-1:0];
      quo_next = {quo[DIVIDEND_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* src/prepaid_time_credit_meter.sv */
// ----------------------------------------------------------------------------
// prepaid_time_credit_meter
// Time-credit meter: restore, add money, refund query, display tick and
// minute tick, with add and refund scaled through a shared multiply/divide.
// Restore, display, minute and unknown items: result loaded from ST_DECODE.
// Add money and refund: ST_MUL, ST_SCALE, the 36-step shared divider, ST_DONE.
// One item at a time; a new item is taken once the result register is loaded.
// Reset: credit 100, flash phase and save count 0, rates 1, factory mode off.
// ----------------------------------------------------------------------------
module prepaid_time_credit_meter #(
  parameter int CREDIT_CAP    = 14400,
  parameter int SAVE_INTERVAL = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  ptcm_pkg::item_t                      item,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output ptcm_pkg::result_t                    result,
  input  logic                                 cfg_write,
  input  logic [ptcm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ptcm_pkg::WORD_W-1:0]          cfg_data
);
  import ptcm_pkg::*;

  localparam logic [CREDIT_W-1:0] CAP     = CREDIT_W'(CREDIT_CAP);
  localparam logic [WORD_W-1:0]   CAP_W   = WORD_W'(CREDIT_CAP);
  localparam logic [CNT_W:0]      SAVE_IV = (CNT_W + 1)'(SAVE_INTERVAL);
  localparam logic [CREDIT_W-1:0] TEN     = CREDIT_W'(10);

  state_t              state, state_next;
  item_t               item_r;
  logic [WORD_W-1:0]   time_per_unit;
  logic [WORD_W-1:0]   money_per_unit;
  logic                factory_mode;
  logic [CREDIT_W-1:0] credit, credit_next;
  logic                flash_phase, flash_phase_next;
  logic [CNT_W-1:0]    save_cnt, save_cnt_next;
  logic [PROD_W-1:0]   prod;
  logic                result_load;
  result_t             result_next;

  logic [WORD_W-1:0]       mul_a, mul_b;
  logic [WORD_W-1:0]       tpu_nz, mpu_nz;
  logic [DIVISOR_W-1:0]    tpu_x;
  logic [DIVIDEND_W-1:0]   prod_x;
  logic [DIV10_PROD_W-1:0] disp_prod;
  logic [CNT_W:0]          cnt_inc;
  logic [CREDIT_W:0]       add_sum;
  logic [CREDIT_W-1:0]     add_sat;
  logic                    out_free;
  logic                    is_add;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  ptcm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != ST_IDLE);
  assign is_add     = (item_r.opcode == OP_ADD);
  assign tpu_nz     = (time_per_unit == '0) ? WORD_W'(1) : time_per_unit;
  assign mpu_nz     = (money_per_unit == '0) ? WORD_W'(1) : money_per_unit;
  assign mul_a      = is_add ? item_r.money_amount : WORD_W'(credit);
  assign mul_b      = is_add ? time_per_unit : money_per_unit;
  assign tpu_x      = (DIVISOR_W'(tpu_nz) << 3) + (DIVISOR_W'(tpu_nz) << 1);
  assign prod_x     = (DIVIDEND_W'(prod) << 3) + (DIVIDEND_W'(prod) << 1);
  assign disp_prod  = DIV10_PROD_W'(credit) * DIV10_PROD_W'(DIV10_RECIP);
  assign cnt_inc    = {1'b0, save_cnt} + 1'b1;

  always_comb begin
    div_req.start    = (state == ST_SCALE);
    div_req.dividend = is_add ? prod_x : DIVIDEND_W'(prod);
    div_req.divisor  = is_add ? DIVISOR_W'(mpu_nz) : tpu_x;
  end

  // saturating add of the scaled credit
  always_comb begin
    if (|div_rsp.quotient[DIVIDEND_W-1:CREDIT_W]) begin
      add_sum = {1'b0, CAP};
    end else begin
      add_sum = {1'b0, credit} + {1'b0, div_rsp.quotient[CREDIT_W-1:0]};
    end
    add_sat = (add_sum > {1'b0, CAP}) ? CAP : add_sum[CREDIT_W-1:0];
  end

  always_comb begin
    state_next       = state;
    credit_next      = credit;
    flash_phase_next = flash_phase;
    save_cnt_next    = save_cnt;
    result_load      = 1'b0;
    result_next      = '0;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (item_r.opcode == OP_ADD || item_r.opcode == OP_REFUND) begin
          state_next = ST_MUL;
        end else if (out_free) begin
          state_next  = ST_IDLE;
          result_load = 1'b1;
          case (item_r.opcode)
            OP_RESTORE: begin
              if (!item_r.load_ok || item_r.load_value > CAP_W) begin
                credit_next              = '0;
                result_next.save_request = 1'b1;
                result_next.clear_event  = 1'b1;
              end else begin
                credit_next = item_r.load_value[CREDIT_W-1:0];
              end
            end
            OP_DISPLAY: begin
              if (!factory_mode) begin
                result_next.display_valid = 1'b1;
                if (credit != '0) begin
                  flash_phase_next            = ~flash_phase;
                  result_next.display_minutes =
                    disp_prod[DIV10_SHIFT +: DISP_W];
                  result_next.flash_bit       = ~flash_phase;
                  result_next.relay_on        = 1'b1;
                end
              end
            end
            OP_MINUTE: begin
              if (credit > TEN) begin
                credit_next = credit - TEN;
              end else if (credit != '0) begin
                credit_next              = '0;
                result_next.save_request = 1'b1;
                result_next.clear_event  = 1'b1;
              end
              if (cnt_inc >= SAVE_IV) begin
                save_cnt_next = '0;
                if (credit_next != '0) begin
                  result_next.save_request = 1'b1;
                end
              end else begin
                save_cnt_next = cnt_inc[CNT_W-1:0];
              end
            end
            default: begin
            end
          endcase
          result_next.time_left = credit_next;
        end
      end
      ST_MUL: begin
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next  = ST_IDLE;
          result_load = 1'b1;
          if (is_add) begin
            credit_next              = add_sat;
            result_next.save_request = 1'b1;
          end else if (|div_rsp.quotient[DIVIDEND_W-1:WORD_W]) begin
            result_next.refund_amount = '1;
          end else begin
            result_next.refund_amount = div_rsp.quotient[WORD_W-1:0];
          end
          result_next.time_left = credit_next;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      credit         <= CREDIT_W'(100);
      flash_phase    <= 1'b0;
      save_cnt       <= '0;
      result_valid   <= 1'b0;
      time_per_unit  <= WORD_W'(1);
      money_per_unit <= WORD_W'(1);
      factory_mode   <= 1'b0;
    end else begin
      state       <= state_next;
      credit      <= credit_next;
      flash_phase <= flash_phase_next;
      save_cnt    <= save_cnt_next;
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_TIME_PER_UNIT:  time_per_unit  <= cfg_data;
          CFG_MONEY_PER_UNIT: money_per_unit <= cfg_data;
          CFG_FACTORY_MODE:   factory_mode   <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      item_r <= item;
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (result_load) begin
      result <= result_next;
    end
  end

endmodule
